// ----- rtl/core/mvm_pkg.sv -----
`timescale 1ns / 1ps
// Package for the multi-voice one-shot sample mixer.
// Field widths, action codes and parameter defaults; depends on nothing.
package mvm_pkg;

  // Payload field widths
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned VOICE_W  = 4;
  localparam int unsigned ADDR_W   = 15;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CFG_W    = 3;

  // Voice length and play pointer, up to the full address range plus one
  localparam int unsigned LEN_W = ADDR_W + 1;

  // Parameter defaults
  localparam int unsigned NUM_VOICES_DEF   = 16;
  localparam int unsigned SAMPLE_DEPTH_DEF = 32768;

  // Gain shift after reset
  localparam logic [CFG_W-1:0] MIX_SHIFT_RST = 3'd1;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TRIGGER = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd2;

endpackage

// ----- rtl/core/mvm_item_if.sv -----
`timescale 1ns / 1ps
// Input channel of the mixer: tick, trigger and sample load transactions.
// Depends on mvm_pkg.
interface mvm_item_if;
  import mvm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic [VOICE_W-1:0]         voice;
  logic [ADDR_W-1:0]          address;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic                       last_word;

  modport source (output valid, action, voice, address, sample_value, last_word,
                  input ready);
  modport sink   (input valid, action, voice, address, sample_value, last_word,
                  output ready);
endinterface

// ----- rtl/core/mvm_result_if.sv -----
`timescale 1ns / 1ps
// Output channel of the mixer: one mixed sample per tick.
// Depends on mvm_pkg.
interface mvm_result_if;
  import mvm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] mixed_sample;
  logic                       clipped;

  modport source (output valid, mixed_sample, clipped, input ready);
  modport sink   (input valid, mixed_sample, clipped, output ready);
endinterface

// ----- rtl/core/mvm_cfg_if.sv -----
`timescale 1ns / 1ps
// Configuration write channel of the mixer: carries the gain shift.
// Depends on mvm_pkg.
interface mvm_cfg_if;
  import mvm_pkg::*;

  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/core/multi_voice_one_shot_sample_mixer.sv -----
`timescale 1ns / 1ps
// Channel    Role   Handshake      Payload
// item_i     sink   valid/ready    action, voice, address, sample_value, last_word
// result_o   source valid/ready    mixed_sample, clipped
// cfg_i      sink   valid/ready    data (mix shift, 3 bits)
//
// Trigger and load transactions leave the input ready. A tick walks the voices
// through one shared read-and-advance step, one voice a cycle, over a
// three-deep pipe (state read, sample read, accumulate), then shifts and
// saturates into the result register; the input is ready again only once
// the sequencer is back in idle, so no item is taken while a tick is mixed.
// The result register frees the output side; a tick waits in the saturate
// step only while the previous result is still untaken.
// Reset clears voice flags and length-valid bits at once; no clearing pass.
// Depends on mvm_pkg and the three channel interfaces.
module multi_voice_one_shot_sample_mixer #(
  parameter int unsigned NUM_VOICES   = mvm_pkg::NUM_VOICES_DEF,
  parameter int unsigned SAMPLE_DEPTH = mvm_pkg::SAMPLE_DEPTH_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  mvm_item_if.sink     item_i,
  mvm_result_if.source result_o,
  mvm_cfg_if.sink      cfg_i
);
  import mvm_pkg::*;

  localparam int unsigned VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int unsigned MEM_DEPTH = NUM_VOICES * SAMPLE_DEPTH;
  localparam int unsigned MEM_AW = $clog2(MEM_DEPTH);
  localparam int unsigned SUM_W = SAMPLE_W + 1 + $clog2(NUM_VOICES);
  localparam logic [31:0] DEPTH32 = 32'(SAMPLE_DEPTH);
  localparam logic [31:0] NV32 = 32'(NUM_VOICES);
  localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(NUM_VOICES - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32'sd32767);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-32'sd32768);

  // Sequencer codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MIX  = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [CFG_W-1:0] mix_shift_q;

  // Stores
  logic signed [SAMPLE_W-1:0] smp_mem [MEM_DEPTH];
  logic [LEN_W-1:0] len_mem [NUM_VOICES];
  logic [LEN_W-1:0] ptr_mem [NUM_VOICES];

  // Per-voice flags
  logic [NUM_VOICES-1:0] play_q, play_d;
  logic [NUM_VOICES-1:0] pend_q, pend_d;
  logic [NUM_VOICES-1:0] lval_q, lval_d;

  // Voice walk
  logic              issue_q;
  logic [VIDX_W-1:0] idx_q;
  logic              p1_vld_q;
  logic [VIDX_W-1:0] p1_idx_q;
  logic [LEN_W-1:0]  len_rd_q;
  logic [LEN_W-1:0]  ptr_rd_q;
  logic              p2_vld_q;
  logic signed [SAMPLE_W-1:0] smp_rd_q;
  logic signed [SUM_W-1:0] sum_q;

  // Result register
  logic                       res_vld_q;
  logic signed [SAMPLE_W-1:0] res_smp_q;
  logic                       res_clip_q;

  // Input decode
  logic              item_acc;
  logic              voice_ok;
  logic              addr_ok;
  logic              do_tick;
  logic              do_trig;
  logic              do_load;
  logic [VIDX_W-1:0] in_vidx;
  logic [MEM_AW-1:0] wr_addr;

  // Walk step signals
  logic [LEN_W-1:0]  len1;
  logic [LEN_W-1:0]  ptr1;
  logic [LEN_W-1:0]  ptr_nx;
  logic              act1;
  logic              hit1;
  logic              still1;
  logic [MEM_AW-1:0] rd_addr;

  // Saturation
  logic signed [SUM_W-1:0] shifted;
  logic                    out_free;
  logic                    sat_hi;
  logic                    sat_lo;

  assign item_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign item_acc = item_i.valid && item_i.ready;

  assign voice_ok = (32'(item_i.voice) < NV32);
  assign addr_ok = (32'(item_i.address) < DEPTH32);
  assign in_vidx = VIDX_W'(item_i.voice);
  assign do_tick = item_acc && (item_i.action == ACT_TICK);
  assign do_trig = item_acc && (item_i.action == ACT_TRIGGER) && voice_ok;
  assign do_load = item_acc && (item_i.action == ACT_LOAD) && voice_ok && addr_ok;
  assign wr_addr = MEM_AW'(32'(in_vidx) * DEPTH32 + 32'(item_i.address));

  // Evaluate one voice: consume a trigger, check the end, advance
  always_comb begin
    len1 = lval_q[p1_idx_q] ? len_rd_q : '0;
    ptr1 = pend_q[p1_idx_q] ? '0 : ptr_rd_q;
    act1 = pend_q[p1_idx_q] || play_q[p1_idx_q];
    hit1 = act1 && (ptr1 < len1);
    ptr_nx = ptr1 + LEN_W'(1);
    still1 = hit1 && (ptr_nx < len1);
    rd_addr = MEM_AW'(32'(p1_idx_q) * DEPTH32 + 32'(ptr1));
  end

  // Next values of the voice flags
  always_comb begin
    play_d = play_q;
    pend_d = pend_q;
    lval_d = lval_q;
    if (do_trig) begin
      pend_d[in_vidx] = 1'b1;
    end
    if (do_load && item_i.last_word) begin
      lval_d[in_vidx] = 1'b1;
    end
    if (p1_vld_q) begin
      pend_d[p1_idx_q] = 1'b0;
      play_d[p1_idx_q] = still1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      play_q <= '0;
      pend_q <= '0;
      lval_q <= '0;
    end else begin
      play_q <= play_d;
      pend_q <= pend_d;
      lval_q <= lval_d;
    end
  end

  // Sample memory: load write, walk read
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      smp_mem[wr_addr] <= item_i.sample_value;
    end
    if (p1_vld_q && hit1) begin
      smp_rd_q <= smp_mem[rd_addr];
    end
  end

  // Length store: write on the last word, read at the walk index
  always_ff @(posedge clk_i) begin
    if (do_load && item_i.last_word) begin
      len_mem[in_vidx] <= LEN_W'(item_i.address) + LEN_W'(1);
    end
    if (issue_q) begin
      len_rd_q <= len_mem[idx_q];
    end
  end

  // Pointer store: write back the advanced pointer
  always_ff @(posedge clk_i) begin
    if (p1_vld_q && hit1) begin
      ptr_mem[p1_idx_q] <= ptr_nx;
    end
    if (issue_q) begin
      ptr_rd_q <= ptr_mem[idx_q];
    end
  end

  // Next sequencer state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (do_tick) begin
          state_d = ST_MIX;
        end
      end
      ST_MIX: begin
        if (!issue_q && !p1_vld_q && !p2_vld_q) begin
          state_d = ST_SAT;
        end
      end
      ST_SAT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Walk the voices and accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issue_q  <= 1'b0;
      idx_q    <= '0;
      p1_vld_q <= 1'b0;
      p1_idx_q <= '0;
      p2_vld_q <= 1'b0;
      sum_q    <= '0;
    end else begin
      state_q  <= state_d;
      p1_vld_q <= issue_q;
      p2_vld_q <= p1_vld_q && hit1;
      if (issue_q) begin
        p1_idx_q <= idx_q;
      end
      if (do_tick) begin
        issue_q <= 1'b1;
        idx_q   <= '0;
        sum_q   <= '0;
      end else begin
        if (issue_q) begin
          if (idx_q == LAST_VOICE) begin
            issue_q <= 1'b0;
          end else begin
            idx_q <= idx_q + VIDX_W'(1);
          end
        end
        if (p2_vld_q) begin
          sum_q <= sum_q + SUM_W'(smp_rd_q);
        end
      end
    end
  end

  // Apply gain and saturate
  assign shifted = sum_q >>> mix_shift_q;
  assign sat_hi = (shifted > SAT_HI);
  assign sat_lo = (shifted < SAT_LO);
  assign out_free = !res_vld_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if ((state_q == ST_SAT) && out_free) begin
      res_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_SAT) && out_free) begin
      res_clip_q <= sat_hi || sat_lo;
      if (sat_hi) begin
        res_smp_q <= SAMPLE_W'(SAT_HI);
      end else if (sat_lo) begin
        res_smp_q <= SAMPLE_W'(SAT_LO);
      end else begin
        res_smp_q <= SAMPLE_W'(shifted);
      end
    end
  end

  assign result_o.valid = res_vld_q;
  assign result_o.mixed_sample = res_smp_q;
  assign result_o.clipped = res_clip_q;

  // Hold the gain shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_shift_q <= MIX_SHIFT_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      mix_shift_q <= cfg_i.data;
    end
  end

`ifndef SYNTH
  a_ready_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.ready |-> (!issue_q && !p1_vld_q && !p2_vld_q))
    else $error("input ready while the voice walk is busy");

  a_triggers_consumed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SAT) |-> (pend_q == '0))
    else $error("trigger left pending after a full voice walk");

  a_clip_at_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.clipped) |->
      (result_o.mixed_sample == 16'sh7fff || result_o.mixed_sample == 16'sh8000))
    else $error("clip flag set off the saturation rail");

  a_walk_starts_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(issue_q) |-> ($past(do_tick) && idx_q == '0))
    else $error("voice walk started without a tick");
`endif

endmodule
